FILE: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants for the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int MAX_SETS_DEF  = 1024;
   localparam int WAYS_DEF      = 8;
   localparam int ADDR_BITS_DEF = 32;

   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_SIZE_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_COUNT_LOG2 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE    = 2'd2;

   localparam logic [CFG_W-1:0] LINE_LOG2_RST = 4'd6;
   localparam logic [CFG_W-1:0] SET_LOG2_RST  = 4'd6;
   localparam logic [CFG_W-1:0] WAYS_RST      = 4'd8;
   localparam logic [CFG_W-1:0] LINE_LOG2_MAX = 4'd12;

   localparam int COUNT_W     = 48;
   localparam int SET_INDEX_W = 10;
   localparam int TAG_VALUE_W = 32;
   localparam int WAY_USED_W  = 3;

   localparam int RSP_FIELDS_W = SET_INDEX_W + TAG_VALUE_W + WAY_USED_W + 2 * COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam int QUEUE_DEPTH = 2;

endpackage

FILE: rtl/set_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup: the lookup engine starts a request only after the last one has
// written back its set row in the line memories; the result is registered with the write back.
// Reset loads default config, clears counters, then sweeps all MAX_SETS valid and rank
// rows with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
   parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
   parameter int WAYS      = salc_pkg::WAYS_DEF,
   parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: address
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((ADDR_BITS + 7) / 8) * 8-1:0] req_tdata,
   // rsp_tuser: hit
   // rsp_tdata: set_index, tag_value, way_used, hit_count, miss_count
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,
   output logic [salc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [salc_pkg::CFG_W-1:0]          csr_data
);
   import salc_pkg::*;

   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_CNT_W = $clog2(WAYS + 1);
   localparam int Q_W       = ADDR_BITS + SET_W;

   logic                 back_busy;
   logic                 fq_valid;
   logic                 fq_ready;
   logic [SET_W-1:0]     fq_set;
   logic [ADDR_BITS-1:0] fq_tag;
   logic [WAY_CNT_W-1:0] ways_eff;
   logic                 qb_valid;
   logic                 qb_ready;
   logic [Q_W-1:0]       qb_data;

   salc_front #(
      .MAX_SETS  (MAX_SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .back_busy  (back_busy),
      .q_ready    (fq_ready),
      .q_valid    (fq_valid),
      .q_set      (fq_set),
      .q_tag      (fq_tag),
      .ways_eff   (ways_eff)
   );

   salc_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_tag, fq_set}),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   salc_back #(
      .MAX_SETS  (MAX_SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (qb_valid),
      .q_ready    (qb_ready),
      .q_set      (qb_data[SET_W-1:0]),
      .q_tag      (qb_data[Q_W-1:SET_W]),
      .ways_eff   (ways_eff),
      .busy       (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front
// Configuration registers and request decode into set index and tag.
// ----------------------------------------------------------------------------
module salc_front #(
   parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
   parameter int WAYS      = salc_pkg::WAYS_DEF,
   parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
   localparam int WAY_CNT_W = $clog2(WAYS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((ADDR_BITS + 7) / 8) * 8-1:0] req_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [salc_pkg::CFG_W-1:0]          csr_data,
   input  logic                                back_busy,
   input  logic                                q_ready,
   output logic                                q_valid,
   output logic [SET_W-1:0]                    q_set,
   output logic [ADDR_BITS-1:0]                q_tag,
   output logic [WAY_CNT_W-1:0]                ways_eff
);
   import salc_pkg::*;

   localparam int SET_LOG2_MAX = $clog2(MAX_SETS + 1) - 1;

   logic [CFG_W-1:0]     line_log2_ff, line_log2_in;
   logic [CFG_W-1:0]     set_log2_ff, set_log2_in;
   logic [CFG_W-1:0]     ways_ff, ways_in;
   logic [CFG_W-1:0]     ls_eff;
   logic [4:0]           sl_eff;
   logic [ADDR_BITS-1:0] address;
   logic [ADDR_BITS-1:0] line_no;

   assign csr_ready = 1'b1;

   always_comb begin
      line_log2_in = line_log2_ff;
      set_log2_in  = set_log2_ff;
      ways_in      = ways_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LINE_SIZE_LOG2: line_log2_in = csr_data;
            CSR_SET_COUNT_LOG2: set_log2_in  = csr_data;
            CSR_WAYS_IN_USE:    ways_in      = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_log2_ff <= LINE_LOG2_RST;
         set_log2_ff  <= SET_LOG2_RST;
         ways_ff      <= WAYS_RST;
      end else begin
         line_log2_ff <= line_log2_in;
         set_log2_ff  <= set_log2_in;
         ways_ff      <= ways_in;
      end
   end

   assign ls_eff = (line_log2_ff > LINE_LOG2_MAX) ? LINE_LOG2_MAX : line_log2_ff;
   assign sl_eff = (int'(set_log2_ff) > SET_LOG2_MAX) ? 5'(SET_LOG2_MAX)
                                                       : {1'b0, set_log2_ff};

   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WAY_CNT_W'(1);
      end else if (int'(ways_ff) > WAYS) begin
         ways_eff = WAY_CNT_W'(WAYS);
      end else begin
         ways_eff = WAY_CNT_W'(ways_ff);
      end
   end

   assign address = req_tdata[ADDR_BITS-1:0];
   assign line_no = address >> ls_eff;
   assign q_set   = SET_W'(line_no) & ~({SET_W{1'b1}} << sl_eff);
   assign q_tag   = line_no >> sl_eff;

   assign req_tready = q_ready && !back_busy;
   assign q_valid    = req_tvalid && req_tready;

endmodule

FILE: rtl/salc_queue.sv
// ----------------------------------------------------------------------------
// salc_queue
// Small FIFO between request decode and the lookup engine.
// ----------------------------------------------------------------------------
module salc_queue #(
   parameter int DEPTH = salc_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import salc_pkg::*;

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back
// Set read, tag compare, LRU victim choice, row write back and result stage.
// ----------------------------------------------------------------------------
module salc_back #(
   parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
   parameter int WAYS      = salc_pkg::WAYS_DEF,
   parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
   localparam int WAY_CNT_W = $clog2(WAYS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  logic [SET_W-1:0]                   q_set,
   input  logic [ADDR_BITS-1:0]               q_tag,
   input  logic [WAY_CNT_W-1:0]               ways_eff,
   output logic                               busy,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,
   output logic [salc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import salc_pkg::*;

   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = WAY_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [WAYS-1:0][ADDR_BITS-1:0] tag_mem_ff   [MAX_SETS];
   logic [WAYS-1:0]                valid_mem_ff [MAX_SETS];
   logic [WAYS-1:0][RANK_W-1:0]    rank_mem_ff  [MAX_SETS];

   logic [1:0]                     state_ff, state_in;
   logic [SET_W-1:0]               clr_idx_ff, clr_idx_in;
   logic [SET_W-1:0]               cur_set_ff;
   logic [ADDR_BITS-1:0]           cur_tag_ff;
   logic [WAYS-1:0][ADDR_BITS-1:0] rd_tags_ff;
   logic [WAYS-1:0]                rd_valid_ff;
   logic [WAYS-1:0][RANK_W-1:0]    rd_ranks_ff;

   logic [WAYS-1:0]                in_use;
   logic [WAYS-1:0]                hit_vec;
   logic [WAYS-1:0]                inv_vec;
   logic [WAYS-1:0]                max_vec;
   logic                           hit;
   logic [WAY_W-1:0]               way_sel;
   logic                           old_valid;
   logic [RANK_W-1:0]              old_rank;
   logic [WAYS-1:0][ADDR_BITS-1:0] tags_wr;
   logic [WAYS-1:0]                valid_wr;
   logic [WAYS-1:0][RANK_W-1:0]    ranks_wr;

   logic                           pop;
   logic                           go;
   logic [COUNT_W-1:0]             hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]             miss_cnt_ff, miss_cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff;
   logic [SET_INDEX_W-1:0]         rsp_set_ff;
   logic [TAG_VALUE_W-1:0]         rsp_tag_ff;
   logic [WAY_USED_W-1:0]          rsp_way_ff;
   logic [COUNT_W-1:0]             rsp_hits_ff;
   logic [COUNT_W-1:0]             rsp_misses_ff;

   function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] vec);
      logic [WAY_W-1:0] idx;
      idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = WAY_W'(i);
         end
      end
      return idx;
   endfunction

   assign busy    = (state_ff == ST_CLEAR);
   assign pop     = (state_ff == ST_IDLE) && q_valid;
   assign q_ready = pop;
   assign go      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         in_use[w]  = (WAY_CNT_W'(w) < ways_eff);
         hit_vec[w] = in_use[w] && rd_valid_ff[w] && (rd_tags_ff[w] == cur_tag_ff);
         inv_vec[w] = in_use[w] && !rd_valid_ff[w];
      end
   end

   always_comb begin
      logic [WAYS-1:0] older;
      older = '0;
      for (int w = 0; w < WAYS; w++) begin
         for (int v = 0; v < WAYS; v++) begin
            if (in_use[v] && (rd_ranks_ff[v] > rd_ranks_ff[w])) begin
               older[w] = 1'b1;
            end
         end
         max_vec[w] = in_use[w] && !older[w];
      end
   end

   assign hit     = |hit_vec;
   assign way_sel = hit        ? first_one(hit_vec) :
                    (|inv_vec) ? first_one(inv_vec) : first_one(max_vec);

   assign old_valid = rd_valid_ff[way_sel];
   assign old_rank  = rd_ranks_ff[way_sel];

   always_comb begin
      tags_wr  = rd_tags_ff;
      valid_wr = rd_valid_ff;
      ranks_wr = rd_ranks_ff;
      for (int v = 0; v < WAYS; v++) begin
         if (WAY_W'(v) == way_sel) begin
            ranks_wr[v] = '0;
         end else if (rd_valid_ff[v] && (!old_valid || rd_ranks_ff[v] < old_rank)) begin
            ranks_wr[v] = rd_ranks_ff[v] + 1'b1;
         end
      end
      tags_wr[way_sel]  = cur_tag_ff;
      valid_wr[way_sel] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         valid_mem_ff[clr_idx_ff] <= '0;
         rank_mem_ff[clr_idx_ff]  <= '0;
      end else if (go) begin
         valid_mem_ff[cur_set_ff] <= valid_wr;
         rank_mem_ff[cur_set_ff]  <= ranks_wr;
         tag_mem_ff[cur_set_ff]   <= tags_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_tags_ff  <= tag_mem_ff[q_set];
         rd_valid_ff <= valid_mem_ff[q_set];
         rd_ranks_ff <= rank_mem_ff[q_set];
         cur_set_ff  <= q_set;
         cur_tag_ff  <= q_tag;
      end
   end

   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (go && hit && (hit_cnt_ff != '1)) begin
         hit_cnt_in = hit_cnt_ff + 1'b1;
      end
      if (go && !hit && (miss_cnt_ff != '1)) begin
         miss_cnt_in = miss_cnt_ff + 1'b1;
      end
   end

   assign rsp_valid_in = go || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_hit_ff    <= hit;
         rsp_set_ff    <= SET_INDEX_W'(cur_set_ff);
         rsp_tag_ff    <= TAG_VALUE_W'(cur_tag_ff);
         rsp_way_ff    <= WAY_USED_W'(way_sel);
         rsp_hits_ff   <= hit_cnt_in;
         rsp_misses_ff <= miss_cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_misses_ff, rsp_hits_ff, rsp_way_ff,
                        rsp_tag_ff, rsp_set_ff};

`ifndef SYNTH
   a_miss_holds_hits: assert property (@(posedge clock) disable iff (reset)
      go && !hit |=> $stable(hit_cnt_ff))
      else $error("hit counter moved on a miss");

   a_lookup_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) && !go |=> (state_ff == ST_LOOKUP) && $stable(cur_set_ff))
      else $error("stalled lookup lost its set");

   a_way_in_use: assert property (@(posedge clock) disable iff (reset)
      go |-> in_use[way_sel])
      else $error("selected way outside the ways in use");
`endif

endmodule

FILE: bench/tb_set_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_lookup
// Drives byte addresses into the LRU cache lookup and predicts hit, set, tag,
// way and the running counts with a model of its own. Covers min, max and
// out-of-range register settings, way-count shrink with contents kept, and
// long random runs on small working sets. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup;
   import salc_pkg::*;

   localparam int CACHE_SETS   = MAX_SETS_DEF;
   localparam int NUM_WAYS     = WAYS_DEF;
   localparam int SET_LOG2_CAP = $clog2(MAX_SETS_DEF);
   localparam int TAG_LSB      = SET_INDEX_W;
   localparam int WAY_LSB      = TAG_LSB + TAG_VALUE_W;
   localparam int HITS_LSB     = WAY_LSB + WAY_USED_W;
   localparam int MISS_LSB     = HITS_LSB + COUNT_W;

   typedef struct packed {
      logic                   hit;
      logic [SET_INDEX_W-1:0] set_index;
      logic [TAG_VALUE_W-1:0] tag_value;
      logic [WAY_USED_W-1:0]  way_used;
      logic [COUNT_W-1:0]     hit_count;
      logic [COUNT_W-1:0]     miss_count;
   } lookup_result_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          rsp_tuser;
   logic [RSP_DATA_W-1:0]         rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index  = '0;
   logic [CFG_W-1:0]              csr_data   = '0;

   bit [CFG_W-1:0] cfg_line_log2 = LINE_LOG2_RST;
   bit [CFG_W-1:0] cfg_set_log2  = SET_LOG2_RST;
   bit [CFG_W-1:0] cfg_ways      = WAYS_RST;

   bit             way_valid [CACHE_SETS][NUM_WAYS];
   bit [31:0]      way_tag   [CACHE_SETS][NUM_WAYS];
   bit [2:0]       way_rank  [CACHE_SETS][NUM_WAYS];
   bit [COUNT_W-1:0] hits_seen;
   bit [COUNT_W-1:0] misses_seen;

   lookup_result_type expected_lookups [$];
   lookup_result_type want;
   int             mismatch_count = 0;
   bit             no_idle = 1'b0;

   set_assoc_lru_cache_lookup u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready = no_idle || ($urandom_range(0, 99) >= 24);
   end

   function automatic int unsigned eff_line_log2();
      return (cfg_line_log2 > LINE_LOG2_MAX) ? LINE_LOG2_MAX : cfg_line_log2;
   endfunction

   function automatic int unsigned eff_set_log2();
      return (cfg_set_log2 > SET_LOG2_CAP) ? SET_LOG2_CAP : cfg_set_log2;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > NUM_WAYS) return NUM_WAYS;
      return cfg_ways;
   endfunction

   function automatic logic [31:0] compose_address(input logic [31:0] tag,
                                                   input int unsigned set_no,
                                                   input logic [31:0] offset);
      int unsigned ls = eff_line_log2();
      int unsigned sl = eff_set_log2();
      logic [31:0] line_no;
      line_no = (tag << sl) | (set_no & ((32'd1 << sl) - 1));
      return (line_no << ls) | (offset & ((32'd1 << ls) - 1));
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [31:0] addr);
      int unsigned ls, sl, nw, set_no, way, worst, old_rank;
      logic [31:0] line_no;
      logic [31:0] tag;
      bit hit, found;
      lookup_result_type r;
      ls = eff_line_log2();
      sl = eff_set_log2();
      nw = eff_ways();
      line_no = addr >> ls;
      set_no = line_no & ((32'd1 << sl) - 1);
      tag = line_no >> sl;
      hit = 1'b0;
      found = 1'b0;
      way = 0;
      for (int w = 0; w < nw; w++) begin
         if (!hit && way_valid[set_no][w] && way_tag[set_no][w] == tag) begin
            hit = 1'b1;
            way = w;
         end
      end
      if (hit) begin
         if (hits_seen != '1) hits_seen++;
      end else begin
         if (misses_seen != '1) misses_seen++;
         for (int w = 0; w < nw; w++) begin
            if (!found && !way_valid[set_no][w]) begin
               found = 1'b1;
               way = w;
            end
         end
         if (!found) begin
            worst = 0;
            for (int w = 0; w < nw; w++) begin
               if (w == 0 || way_rank[set_no][w] > worst) begin
                  worst = way_rank[set_no][w];
                  way = w;
               end
            end
         end
      end
      old_rank = way_valid[set_no][way] ? way_rank[set_no][way] : NUM_WAYS + 1;
      for (int v = 0; v < NUM_WAYS; v++) begin
         if (v != way && way_valid[set_no][v] && way_rank[set_no][v] < old_rank)
            way_rank[set_no][v]++;
      end
      way_rank[set_no][way] = '0;
      way_valid[set_no][way] = 1'b1;
      way_tag[set_no][way] = tag;
      r.hit = hit;
      r.set_index = SET_INDEX_W'(set_no);
      r.tag_value = tag;
      r.way_used = WAY_USED_W'(way);
      r.hit_count = hits_seen;
      r.miss_count = misses_seen;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_val,
                              input logic [COUNT_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            $error("unexpected result: set %0h tag %0h",
                   rsp_tdata[SET_INDEX_W-1:0], rsp_tdata[TAG_LSB +: TAG_VALUE_W]);
            mismatch_count++;
         end else begin
            want = expected_lookups.pop_front();
            check_field("hit", want.hit, rsp_tuser);
            check_field("set_index", want.set_index, rsp_tdata[SET_INDEX_W-1:0]);
            check_field("tag_value", want.tag_value, rsp_tdata[TAG_LSB +: TAG_VALUE_W]);
            check_field("way_used", want.way_used, rsp_tdata[WAY_LSB +: WAY_USED_W]);
            check_field("hit_count", want.hit_count, rsp_tdata[HITS_LSB +: COUNT_W]);
            check_field("miss_count", want.miss_count, rsp_tdata[MISS_LSB +: COUNT_W]);
         end
      end
   end

   task automatic send_address(input logic [31:0] addr);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = addr;
      do @(posedge clock); while (!req_tready);
      expected_lookups.push_back(predict_lookup(addr));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_lookups.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LINE_SIZE_LOG2: cfg_line_log2 = val;
         CSR_SET_COUNT_LOG2: cfg_set_log2 = val;
         CSR_WAYS_IN_USE:    cfg_ways = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] line_log2,
                               input logic [CFG_W-1:0] set_log2,
                               input logic [CFG_W-1:0] ways);
      wait_drained();
      write_csr(CSR_LINE_SIZE_LOG2, line_log2);
      write_csr(CSR_SET_COUNT_LOG2, set_log2);
      write_csr(CSR_WAYS_IN_USE, ways);
   endtask

   task automatic test_lru_eviction();
      send_address(32'h0000_0000);
      send_address(32'h0000_003F);
      send_address(32'hFFFF_FFFF);
      for (int t = 1; t <= 8; t++) send_address(compose_address(t, 0, 0));
   endtask

   task automatic test_way_shrink();
      set_geometry(LINE_LOG2_RST, SET_LOG2_RST, 4'd2);
      send_address(compose_address(5, 0, 0));
      set_geometry(LINE_LOG2_RST, SET_LOG2_RST, 4'd8);
      send_address(compose_address(5, 0, 0));
   endtask

   task automatic test_register_extremes();
      set_geometry(4'd0, 4'd0, 4'd1);
      send_address(32'h0000_0001);
      send_address(32'h0000_0001);
      send_address(32'h0000_0002);
      set_geometry(LINE_LOG2_MAX, 4'd10, 4'd8);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_0000);
      set_geometry(4'd15, 4'd15, 4'd0);
      send_address(32'hAAAA_AAAA);
      send_address(32'h5555_5555);
      set_geometry(4'd13, 4'd11, 4'd15);
      send_address(32'hDEAD_BEEF);
   endtask

   task automatic test_random_traffic();
      logic [31:0]  pool_tag [12];
      int unsigned  pool_set [2];
      int unsigned  pool_n;
      for (int p = 0; p < 8; p++) begin
         no_idle = (p == 0);
         if (p == 1) set_geometry(4'd0, 4'd0, 4'd1);
         else if (p == 2) set_geometry(LINE_LOG2_MAX, 4'd10, 4'd8);
         else set_geometry(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                           CFG_W'($urandom_range(0, 15)));
         pool_n = eff_ways() + 3;
         for (int i = 0; i < pool_n; i++) pool_tag[i] = $urandom();
         pool_set[0] = $urandom();
         pool_set[1] = $urandom();
         for (int i = 0; i < 100; i++) begin
            if (p == 4 && i == 50) wait_drained();
            if ($urandom_range(0, 99) < 75)
               send_address(compose_address(pool_tag[$urandom_range(0, pool_n - 1)],
                                            pool_set[$urandom_range(0, 1)], $urandom()));
            else
               send_address($urandom());
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_lru_eviction();
      test_way_shrink();
      test_register_extremes();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
